// File: sv/srlb_pkg.sv
// Shared types and constants for the source rate limit blocker.
`default_nettype none
package srlb_pkg;

  localparam logic [15:0] ETHER_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SECONDS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYN_BLOCK_EN   = 3'd4;

  localparam logic [2:0] V_PASS      = 3'd0;
  localparam logic [2:0] V_NOT_IP    = 3'd1;
  localparam logic [2:0] V_DROPPED   = 3'd2;
  localparam logic [2:0] V_SYN       = 3'd3;
  localparam logic [2:0] V_RATE      = 3'd4;
  localparam logic [2:0] V_FULL      = 3'd5;
  localparam logic [2:0] V_UNBLOCKED = 3'd6;
  localparam logic [2:0] V_TICK      = 3'd7;

  localparam int ENTRY_W = 80;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] count;
    logic [31:0] start_time;
  } entry_t;

endpackage
`default_nettype wire

// File: sv/source_rate_limit_blocker_core.sv
// Top level of the source rate limit blocker: table walk, verdicts, tick sweep.
// A packet walks the table one entry per cycle through the registered read port of the
// entry RAM (N = TABLE_ENTRIES); non-IPv4 packets and ticks without sweep skip the walk.
// in_stall is high while busy, so one packet or tick is handled at a time.
// A sweeping tick walks N entries, pausing on output stalls, and holds each found entry
// back to mark the last result. Synchronous reset clears valid/blocked bits.
`default_nettype none
module source_rate_limit_blocker_core
  import srlb_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_opcode,
  input  wire  [15:0]          in_ether_type,
  input  wire  [31:0]          in_src_ip,
  input  wire  [7:0]           in_ip_protocol,
  input  wire                  in_tcp_syn,
  input  wire                  in_tcp_ack,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [2:0]           out_verdict,
  output logic [31:0]          out_address,
  output logic [15:0]          out_packet_count,
  output logic                 out_last,
  input  wire                  cfg_wr_en,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] N_ENT = CW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_SWEEP, S_SLAST, S_SDONE
  } state_t;

  state_t state_r;

  logic [15:0] rate_threshold_r, window_seconds_r;
  logic [16:0] block_seconds_r;
  logic [11:0] sweep_period_r;
  logic        syn_block_en_r;
  logic [31:0] now_r;
  logic [11:0] countdown_r;
  logic [TABLE_ENTRIES-1:0] valid_r, blocked_r;

  logic [15:0] ether_r;
  logic [31:0] src_r;
  logic [7:0]  proto_r;
  logic        syn_r, ack_r;

  logic [CW-1:0] idx_r;
  logic [IW-1:0] prev_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  entry_t        hit_ent_r;
  logic          any_r;
  logic [31:0]   pend_addr_r;
  logic [15:0]   pend_cnt_r;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;

  logic          out_valid_r, out_last_r;
  logic [2:0]    out_verdict_r;
  logic [31:0]   out_address_r;
  logic [15:0]   out_count_r;
  logic          rd_ok;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [31:0]   elapsed;
  logic [15:0]   cnt_inc;
  logic [11:0]   cd_inc;
  logic          out_busy;
  logic          out_load;
  logic          sweep_chk;
  logic          sweep_hit;
  logic          sweep_hold;

  srlb_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_ok   = valid_r[prev_r];
  assign elapsed = now_r - rd_data.start_time;
  assign cnt_inc = (hit_ent_r.count == 16'hFFFF) ? hit_ent_r.count : hit_ent_r.count + 16'd1;
  assign cd_inc  = countdown_r + 12'd1;

  assign out_busy   = out_valid_r && out_stall;
  assign sweep_chk  = (state_r == S_SWEEP && idx_r != '0) || state_r == S_SLAST;
  assign sweep_hit  = rd_ok && blocked_r[prev_r] && (elapsed >= {15'd0, block_seconds_r});
  assign sweep_hold = sweep_chk && sweep_hit && any_r && out_busy;
  assign rd_addr    = sweep_hold ? prev_r : idx_r[IW-1:0];
  assign out_load   = (sweep_chk && sweep_hit && any_r && !out_busy) ||
                      ((state_r == S_SDONE || state_r == S_DECIDE) && !out_busy);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx_r;
    wr_data = hit_ent_r;
    if (state_r == S_DECIDE && ether_r == ETHER_IPV4) begin
      if (hit_r) begin
        if (!blocked_r[hit_idx_r]) begin
          wr_en = 1'b1;
          if (syn_block_en_r && proto_r == PROTO_TCP && syn_r && !ack_r) begin
            wr_data.start_time = now_r;
          end else if ((now_r - hit_ent_r.start_time) > {16'd0, window_seconds_r}) begin
            wr_data.count      = 16'd1;
            wr_data.start_time = now_r;
          end else begin
            wr_data.count = cnt_inc;
            if (cnt_inc > rate_threshold_r) begin
              wr_data.start_time = now_r;
            end
          end
        end
      end else if (free_found) begin
        wr_en              = 1'b1;
        wr_addr            = free_idx;
        wr_data.address    = src_r;
        wr_data.start_time = now_r;
        wr_data.count      = (syn_block_en_r && proto_r == PROTO_TCP && syn_r && !ack_r)
                             ? 16'd0 : 16'd1;
      end
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_address      = out_address_r;
  assign out_packet_count = out_count_r;
  assign out_last         = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      rate_threshold_r <= 16'd50;
      window_seconds_r <= 16'd10;
      block_seconds_r  <= 17'd1800;
      sweep_period_r   <= 12'd60;
      syn_block_en_r   <= 1'b1;
      now_r            <= '0;
      countdown_r      <= '0;
      valid_r          <= '0;
      blocked_r        <= '0;
      out_valid_r      <= 1'b0;
      idx_r            <= '0;
      prev_r           <= '0;
      hit_r            <= 1'b0;
      any_r            <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RATE_THRESHOLD: rate_threshold_r <= cfg_wdata[15:0];
          REG_WINDOW_SECONDS: window_seconds_r <= cfg_wdata[15:0];
          REG_BLOCK_SECONDS:  block_seconds_r  <= cfg_wdata;
          REG_SWEEP_PERIOD:   sweep_period_r   <= cfg_wdata[11:0];
          REG_SYN_BLOCK_EN:   syn_block_en_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ether_r <= in_ether_type;
            src_r   <= in_src_ip;
            proto_r <= in_ip_protocol;
            syn_r   <= in_tcp_syn;
            ack_r   <= in_tcp_ack;
            idx_r   <= '0;
            hit_r   <= 1'b0;
            any_r   <= 1'b0;
            if (in_opcode) begin
              now_r <= now_r + 32'd1;
              if (cd_inc >= sweep_period_r) begin
                countdown_r <= '0;
                state_r     <= S_SWEEP;
              end else begin
                countdown_r <= cd_inc;
                state_r     <= S_SDONE;
              end
            end else if (in_ether_type != ETHER_IPV4) begin
              state_r <= S_DECIDE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN, S_SWEEP: begin
          if (!sweep_hold) begin
            prev_r <= idx_r[IW-1:0];
            idx_r  <= idx_r + CW'(1);
            if (idx_r == N_ENT - CW'(1)) begin
              state_r <= (state_r == S_SCAN) ? S_LAST : S_SLAST;
            end
          end
          if (state_r == S_SCAN && idx_r != '0 && rd_ok && rd_data.address == src_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= prev_r;
            hit_ent_r <= rd_data;
          end
          if (state_r == S_SWEEP && idx_r != '0 && sweep_hit && !sweep_hold) begin
            if (any_r) begin
              out_verdict_r <= V_UNBLOCKED;
              out_address_r <= pend_addr_r;
              out_count_r   <= pend_cnt_r;
              out_last_r    <= 1'b0;
            end
            pend_addr_r       <= rd_data.address;
            pend_cnt_r        <= rd_data.count;
            valid_r[prev_r]   <= 1'b0;
            blocked_r[prev_r] <= 1'b0;
            any_r             <= 1'b1;
          end
        end
        S_LAST: begin
          if (rd_ok && rd_data.address == src_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= prev_r;
            hit_ent_r <= rd_data;
          end
          state_r <= S_DECIDE;
        end
        S_SLAST: begin
          if (!sweep_hold) begin
            state_r <= S_SDONE;
            if (sweep_hit) begin
              if (any_r) begin
                out_verdict_r <= V_UNBLOCKED;
                out_address_r <= pend_addr_r;
                out_count_r   <= pend_cnt_r;
                out_last_r    <= 1'b0;
              end
              pend_addr_r       <= rd_data.address;
              pend_cnt_r        <= rd_data.count;
              valid_r[prev_r]   <= 1'b0;
              blocked_r[prev_r] <= 1'b0;
              any_r             <= 1'b1;
            end
          end
        end
        S_SDONE: begin
          if (!out_busy) begin
            out_last_r <= 1'b1;
            state_r    <= S_IDLE;
            if (any_r) begin
              out_verdict_r <= V_UNBLOCKED;
              out_address_r <= pend_addr_r;
              out_count_r   <= pend_cnt_r;
            end else begin
              out_verdict_r <= V_TICK;
              out_address_r <= '0;
              out_count_r   <= '0;
            end
          end
        end
        S_DECIDE: begin
          if (!out_busy) begin
            out_last_r    <= 1'b1;
            out_address_r <= (ether_r != ETHER_IPV4) ? 32'd0 : src_r;
            state_r       <= S_IDLE;
            if (ether_r != ETHER_IPV4) begin
              out_verdict_r <= V_NOT_IP;
              out_count_r   <= '0;
            end else if (hit_r && blocked_r[hit_idx_r]) begin
              out_verdict_r <= V_DROPPED;
              out_count_r   <= hit_ent_r.count;
            end else if (!hit_r && !free_found) begin
              out_verdict_r <= V_FULL;
              out_count_r   <= '0;
            end else begin
              if (!hit_r) begin
                valid_r[free_idx] <= 1'b1;
              end
              out_count_r <= wr_data.count;
              if (syn_block_en_r && proto_r == PROTO_TCP && syn_r && !ack_r) begin
                out_verdict_r <= V_SYN;
                blocked_r[wr_addr] <= 1'b1;
              end else if (wr_data.count > rate_threshold_r) begin
                out_verdict_r <= V_RATE;
                blocked_r[wr_addr] <= 1'b1;
              end else begin
                out_verdict_r <= V_PASS;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_blk_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((blocked_r & ~valid_r) == '0)) else $error("blocked entry not valid");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_address)) else $error("result changed");
`endif

endmodule
`default_nettype wire

// File: sv/srlb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module srlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
